// File: design/tksc_pkg.sv
// Types, codes and keyword tables shared by the token scanner modules.
package tksc_pkg;

  localparam int unsigned NumKw = 22;

  typedef struct packed {
    logic [20:0] code_point;
    logic        end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [20:0] lexeme_char;
    logic [5:0]  token_kind;
    logic [2:0]  error_code;
    logic        last_of_run;
  } out_item_t;

  // Up to three results from one input, decided in the front end.
  typedef struct packed {
    logic [1:0]  count;
    out_item_t   r0;
    out_item_t   r1;
    out_item_t   r2;
  } bundle_t;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [5:0] TK_END     = 6'd0;
  localparam logic [5:0] TK_WS      = 6'd1;
  localparam logic [5:0] TK_LINE    = 6'd2;
  localparam logic [5:0] TK_EQ      = 6'd3;
  localparam logic [5:0] TK_COLON   = 6'd4;
  localparam logic [5:0] TK_COMMA   = 6'd5;
  localparam logic [5:0] TK_LBRACE  = 6'd6;
  localparam logic [5:0] TK_RBRACE  = 6'd7;
  localparam logic [5:0] TK_LPAREN  = 6'd8;
  localparam logic [5:0] TK_RPAREN  = 6'd9;
  localparam logic [5:0] TK_STRING  = 6'd10;
  localparam logic [5:0] TK_NAME    = 6'd11;
  localparam logic [5:0] TK_INT     = 6'd12;
  localparam logic [5:0] TK_REAL    = 6'd13;
  localparam logic [5:0] TK_LCOM    = 6'd14;
  localparam logic [5:0] TK_MCOM    = 6'd15;
  localparam logic [5:0] TK_KW_BASE = 6'd16;
  localparam logic [5:0] TK_BOOL    = 6'd36;

  localparam logic [2:0] ERR_CHAR   = 3'd0;
  localparam logic [2:0] ERR_ESC    = 3'd1;
  localparam logic [2:0] ERR_STR    = 3'd2;
  localparam logic [2:0] ERR_COM    = 3'd3;
  localparam logic [2:0] ERR_EXP    = 3'd4;
  localparam logic [2:0] ERR_SLASH  = 3'd5;

  localparam logic [3:0] KwLen [NumKw] = '{
    4'd5, 4'd11, 4'd5, 4'd7, 4'd10, 4'd6, 4'd9, 4'd6, 4'd6, 4'd8, 4'd3,
    4'd8, 4'd8, 4'd6, 4'd6, 4'd3, 4'd3, 4'd2, 4'd11, 4'd4, 4'd4, 4'd5
  };

  // Keyword text, 11 bytes each, first character in the top byte.
  localparam logic [87:0] KwText [NumKw] = '{
    "class      ", "constructor", "entry      ", "extends    ",
    "implements ", "method     ", "procedure  ", "native     ",
    "return     ", "variable   ", "add        ", "subtract   ",
    "multiply   ", "divide     ", "negate     ", "not        ",
    "and        ", "or         ", "concatenate", "void       ",
    "true       ", "false      "
  };

  function automatic logic [7:0] kw_char(input int unsigned k, input logic [3:0] p);
    logic [87:0] t;
    t = KwText[k];
    return t[87 - 8 * int'(p) -: 8];
  endfunction

  function automatic out_item_t mk_char(input logic [20:0] c);
    out_item_t r;
    r = '0;
    r.kind = KIND_CHAR;
    r.lexeme_char = c;
    return r;
  endfunction

  function automatic out_item_t mk_end(input logic [5:0] tk);
    out_item_t r;
    r = '0;
    r.kind = KIND_END;
    r.token_kind = tk;
    return r;
  endfunction

  function automatic out_item_t mk_err(input logic [2:0] ec);
    out_item_t r;
    r = '0;
    r.kind = KIND_ERR;
    r.error_code = ec;
    return r;
  endfunction

endpackage

// File: design/tksc_front.sv
// Front end: scanner state machine that turns each beat into a result bundle.
module tksc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tksc_pkg::in_item_t in_data,
  output logic               bq_valid,
  input  logic               bq_full,
  output tksc_pkg::bundle_t  bq_data
);

  typedef enum logic [14:0] {
    M_START = 15'b000000000000001,
    M_WS    = 15'b000000000000010,
    M_CR    = 15'b000000000000100,
    M_STR   = 15'b000000000001000,
    M_ESC   = 15'b000000000010000,
    M_NAME  = 15'b000000000100000,
    M_INT   = 15'b000000001000000,
    M_FRAC  = 15'b000000010000000,
    M_ESIGN = 15'b000000100000000,
    M_EDIG1 = 15'b000001000000000,
    M_EXP   = 15'b000010000000000,
    M_SLASH = 15'b000100000000000,
    M_LCOM  = 15'b001000000000000,
    M_MCOM  = 15'b010000000000000,
    M_MSTAR = 15'b100000000000000
  } mode_t;

  mode_t                          mode_r, mode_nxt;
  logic [tksc_pkg::NumKw-1:0]     cand_r, cand_nxt;
  logic [3:0]                     pos_r, pos_nxt;
  logic                           hold_r, hold_nxt;

  tksc_pkg::out_item_t res [3];
  logic [1:0]          cnt;
  logic                fire;
  logic [20:0]         c;

  assign in_stall = bq_full;
  assign fire     = in_valid && !bq_full;
  assign c        = in_data.code_point;

  function automatic logic is_alpha(input logic [20:0] x);
    return (x >= 21'h41 && x <= 21'h5A) || (x >= 21'h61 && x <= 21'h7A);
  endfunction

  function automatic logic is_digit(input logic [20:0] x);
    return x >= 21'h30 && x <= 21'h39;
  endfunction

  // Keyword narrowing for one name character at position p.
  function automatic logic [tksc_pkg::NumKw-1:0] narrow(
    input logic [tksc_pkg::NumKw-1:0] cd, input logic [3:0] p, input logic [20:0] x);
    logic [tksc_pkg::NumKw-1:0] r;
    r = cd;
    for (int i = 0; i < tksc_pkg::NumKw; i++) begin
      if (p >= tksc_pkg::KwLen[i] || x != {13'd0, tksc_pkg::kw_char(i, p)}) r[i] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [5:0] name_kind(
    input logic [tksc_pkg::NumKw-1:0] cd, input logic [3:0] p);
    logic [5:0] k;
    k = tksc_pkg::TK_NAME;
    for (int i = tksc_pkg::NumKw - 1; i >= 0; i--) begin
      if (cd[i] && tksc_pkg::KwLen[i] == p) begin
        k = (i < 20) ? tksc_pkg::TK_KW_BASE + 6'(i) : tksc_pkg::TK_BOOL;
      end
    end
    return k;
  endfunction

  always_comb begin
    tksc_pkg::out_item_t tmp;
    logic start;
    res[0] = '0;
    res[1] = '0;
    res[2] = '0;
    cnt = 2'd0;
    mode_nxt = mode_r;
    cand_nxt = cand_r;
    pos_nxt = pos_r;
    hold_nxt = hold_r;
    start = 1'b0;
    tmp = '0;
    if (in_data.end_of_input) begin
      if (!hold_r) begin
        case (mode_r)
          M_WS:    begin res[0] = tksc_pkg::mk_end(tksc_pkg::TK_WS); cnt = 2'd1; end
          M_CR:    begin res[0] = tksc_pkg::mk_end(tksc_pkg::TK_LINE); cnt = 2'd1; end
          M_NAME:  begin res[0] = tksc_pkg::mk_end(name_kind(cand_r, pos_r)); cnt = 2'd1; end
          M_INT:   begin res[0] = tksc_pkg::mk_end(tksc_pkg::TK_INT); cnt = 2'd1; end
          M_FRAC, M_EXP: begin res[0] = tksc_pkg::mk_end(tksc_pkg::TK_REAL); cnt = 2'd1; end
          M_LCOM:  begin res[0] = tksc_pkg::mk_end(tksc_pkg::TK_LCOM); cnt = 2'd1; end
          M_STR:   begin res[0] = tksc_pkg::mk_err(tksc_pkg::ERR_STR); cnt = 2'd1; end
          M_ESC:   begin res[0] = tksc_pkg::mk_err(tksc_pkg::ERR_ESC); cnt = 2'd1; end
          M_ESIGN, M_EDIG1: begin res[0] = tksc_pkg::mk_err(tksc_pkg::ERR_EXP); cnt = 2'd1; end
          M_SLASH: begin res[0] = tksc_pkg::mk_err(tksc_pkg::ERR_SLASH); cnt = 2'd1; end
          M_MCOM, M_MSTAR: begin res[0] = tksc_pkg::mk_err(tksc_pkg::ERR_COM); cnt = 2'd1; end
          default: ;
        endcase
        if (cnt == 2'd0 || res[0].kind != tksc_pkg::KIND_ERR) begin
          res[cnt] = tksc_pkg::mk_end(tksc_pkg::TK_END);
          cnt = cnt + 2'd1;
        end
      end
      mode_nxt = M_START;
      cand_nxt = '1;
      pos_nxt = '0;
      hold_nxt = 1'b0;
    end else if (!hold_r) begin
      case (mode_r)
        M_WS: begin
          if (!(c == 21'h20 || c == 21'h09)) begin
            res[0] = tksc_pkg::mk_end(tksc_pkg::TK_WS); cnt = 2'd1; start = 1'b1;
          end
        end
        M_CR: begin
          res[0] = tksc_pkg::mk_end(tksc_pkg::TK_LINE); cnt = 2'd1;
          if (c == 21'h0A) mode_nxt = M_START;
          else start = 1'b1;
        end
        M_STR: begin
          if (c == 21'h5C) mode_nxt = M_ESC;
          else if (c == 21'h22) begin
            res[0] = tksc_pkg::mk_end(tksc_pkg::TK_STRING); cnt = 2'd1; mode_nxt = M_START;
          end else begin
            res[0] = tksc_pkg::mk_char(c); cnt = 2'd1;
          end
        end
        M_ESC: begin
          mode_nxt = M_STR;
          cnt = 2'd1;
          if (c == 21'h22 || c == 21'h5C) res[0] = tksc_pkg::mk_char(c);
          else if (c == 21'h6E) res[0] = tksc_pkg::mk_char(21'h0A);
          else if (c == 21'h72) res[0] = tksc_pkg::mk_char(21'h0D);
          else begin
            res[0] = tksc_pkg::mk_err(tksc_pkg::ERR_ESC); hold_nxt = 1'b1; mode_nxt = M_START;
          end
        end
        M_NAME: begin
          if (c == 21'h5F || is_alpha(c) || is_digit(c)) begin
            res[0] = tksc_pkg::mk_char(c); cnt = 2'd1;
            cand_nxt = narrow(cand_r, pos_r, c);
            pos_nxt = (pos_r == 4'd15) ? 4'd15 : pos_r + 4'd1;
          end else begin
            res[0] = tksc_pkg::mk_end(name_kind(cand_r, pos_r)); cnt = 2'd1; start = 1'b1;
          end
        end
        M_INT: begin
          cnt = 2'd1;
          if (is_digit(c)) res[0] = tksc_pkg::mk_char(c);
          else if (c == 21'h2E) begin
            res[0] = tksc_pkg::mk_char(c); mode_nxt = M_FRAC;
          end else begin
            res[0] = tksc_pkg::mk_end(tksc_pkg::TK_INT); start = 1'b1;
          end
        end
        M_FRAC: begin
          cnt = 2'd1;
          if (is_digit(c)) res[0] = tksc_pkg::mk_char(c);
          else if (c == 21'h65 || c == 21'h45) begin
            res[0] = tksc_pkg::mk_char(c); mode_nxt = M_ESIGN;
          end else begin
            res[0] = tksc_pkg::mk_end(tksc_pkg::TK_REAL); start = 1'b1;
          end
        end
        M_ESIGN: begin
          cnt = 2'd1;
          if (c == 21'h2B || c == 21'h2D) begin
            res[0] = tksc_pkg::mk_char(c); mode_nxt = M_EDIG1;
          end else if (is_digit(c)) begin
            res[0] = tksc_pkg::mk_char(c); mode_nxt = M_EXP;
          end else begin
            res[0] = tksc_pkg::mk_err(tksc_pkg::ERR_EXP); hold_nxt = 1'b1; mode_nxt = M_START;
          end
        end
        M_EDIG1: begin
          cnt = 2'd1;
          if (is_digit(c)) begin
            res[0] = tksc_pkg::mk_char(c); mode_nxt = M_EXP;
          end else begin
            res[0] = tksc_pkg::mk_err(tksc_pkg::ERR_EXP); hold_nxt = 1'b1; mode_nxt = M_START;
          end
        end
        M_EXP: begin
          cnt = 2'd1;
          if (is_digit(c)) res[0] = tksc_pkg::mk_char(c);
          else begin
            res[0] = tksc_pkg::mk_end(tksc_pkg::TK_REAL); start = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == 21'h2A) mode_nxt = M_MCOM;
          else if (c == 21'h2F) mode_nxt = M_LCOM;
          else begin
            res[0] = tksc_pkg::mk_err(tksc_pkg::ERR_SLASH); cnt = 2'd1;
            hold_nxt = 1'b1; mode_nxt = M_START;
          end
        end
        M_LCOM: begin
          cnt = 2'd1;
          if (c == 21'h0D || c == 21'h0A) begin
            res[0] = tksc_pkg::mk_end(tksc_pkg::TK_LCOM); start = 1'b1;
          end else res[0] = tksc_pkg::mk_char(c);
        end
        M_MCOM: begin
          if (c == 21'h2A) mode_nxt = M_MSTAR;
        end
        M_MSTAR: begin
          cnt = 2'd1;
          if (c == 21'h2F) begin
            res[0] = tksc_pkg::mk_end(tksc_pkg::TK_MCOM); mode_nxt = M_START;
          end else begin
            res[0] = tksc_pkg::mk_char(21'h2A);
            mode_nxt = (c == 21'h2A) ? M_MSTAR : M_MCOM;
          end
        end
        default: start = 1'b1;
      endcase
      if (start) begin
        mode_nxt = M_START;
        case (c)
          21'h20, 21'h09: mode_nxt = M_WS;
          21'h0D: mode_nxt = M_CR;
          21'h0A: begin res[cnt] = tksc_pkg::mk_end(tksc_pkg::TK_LINE); cnt = cnt + 2'd1; end
          21'h3D, 21'h3A, 21'h2C, 21'h7B, 21'h7D, 21'h28, 21'h29: begin
            res[cnt] = tksc_pkg::mk_char(c);
            case (c)
              21'h3D:  tmp = tksc_pkg::mk_end(tksc_pkg::TK_EQ);
              21'h3A:  tmp = tksc_pkg::mk_end(tksc_pkg::TK_COLON);
              21'h2C:  tmp = tksc_pkg::mk_end(tksc_pkg::TK_COMMA);
              21'h7B:  tmp = tksc_pkg::mk_end(tksc_pkg::TK_LBRACE);
              21'h7D:  tmp = tksc_pkg::mk_end(tksc_pkg::TK_RBRACE);
              21'h28:  tmp = tksc_pkg::mk_end(tksc_pkg::TK_LPAREN);
              default: tmp = tksc_pkg::mk_end(tksc_pkg::TK_RPAREN);
            endcase
            res[cnt + 2'd1] = tmp;
            cnt = cnt + 2'd2;
          end
          21'h22: mode_nxt = M_STR;
          21'h2F: mode_nxt = M_SLASH;
          default: begin
            if (c == 21'h5F || is_alpha(c)) begin
              res[cnt] = tksc_pkg::mk_char(c); cnt = cnt + 2'd1;
              cand_nxt = narrow('1, 4'd0, c);
              pos_nxt = 4'd1;
              mode_nxt = M_NAME;
            end else if (is_digit(c)) begin
              res[cnt] = tksc_pkg::mk_char(c); cnt = cnt + 2'd1;
              mode_nxt = M_INT;
            end else begin
              res[cnt] = tksc_pkg::mk_err(tksc_pkg::ERR_CHAR); cnt = cnt + 2'd1;
              hold_nxt = 1'b1;
            end
          end
        endcase
      end
    end
    if (cnt != 2'd0) res[cnt - 2'd1].last_of_run = 1'b1;
  end

  assign bq_valid     = fire && cnt != 2'd0;
  assign bq_data.count = cnt;
  assign bq_data.r0   = res[0];
  assign bq_data.r1   = res[1];
  assign bq_data.r2   = res[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_START;
      cand_r <= '1;
      pos_r  <= '0;
      hold_r <= 1'b0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      cand_r <= cand_nxt;
      pos_r  <= pos_nxt;
      hold_r <= hold_nxt;
    end
  end

`ifndef SYNTHESIS
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r |-> mode_r == M_START) else $error("error hold outside start mode");
  a_hold_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_r && !in_data.end_of_input) |-> !bq_valid) else $error("result during hold");
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_data.end_of_input) |=> (!hold_r && pos_r == 4'd0))
    else $error("end mark did not reset");
`endif

endmodule

// File: design/tksc_back.sv
// Back end: bundle queue and serializer that hands results out one beat at a time.
module tksc_back #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                bq_valid,
  output logic                bq_full,
  input  tksc_pkg::bundle_t   bq_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tksc_pkg::out_item_t out_data
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  tksc_pkg::bundle_t mem_r [Depth];
  logic [Aw-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [Aw:0]       cnt_r, cnt_nxt;
  logic [1:0]        sel_r, sel_nxt;
  logic              push, pop, take;
  tksc_pkg::bundle_t head;

  assign bq_full   = cnt_r == Aw'(0) + (Aw+1)'(Depth);
  assign push      = bq_valid && !bq_full;
  assign head      = mem_r[rp_r];
  assign out_valid = cnt_r != '0;
  assign take      = out_valid && !out_stall;
  assign pop       = take && (sel_r + 2'd1 == head.count);

  always_comb begin
    case (sel_r)
      2'd0:    out_data = head.r0;
      2'd1:    out_data = head.r1;
      default: out_data = head.r2;
    endcase
    // Advance within the bundle, drop it after its last result.
    sel_nxt = pop ? 2'd0 : (take ? sel_r + 2'd1 : sel_r);
    wp_nxt  = push ? ((wp_r == Aw'(Depth - 1)) ? '0 : wp_r + Aw'(1)) : wp_r;
    rp_nxt  = pop ? ((rp_r == Aw'(Depth - 1)) ? '0 : rp_r + Aw'(1)) : rp_r;
    cnt_nxt = cnt_r + (Aw+1)'(push) - (Aw+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= bq_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      sel_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
      sel_r <= sel_nxt;
    end
  end

`ifndef SYNTHESIS
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Aw+1)'(Depth)) else $error("queue overflow");
  a_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> sel_r < head.count) else $error("result index beyond bundle");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> (out_data.last_of_run == pop)) else $error("last mark out of step");
`endif

endmodule

// File: design/token_scanner.sv
// Top level of the streaming token scanner: front end plus result queue.
// A beat's results are registered in the bundle queue, then offered.
// Throughput: one input beat per cycle while the bundle queue has room; the
//   output side drains one result per cycle unless stalled, so bursts of up to
//   three results per input are absorbed by the QueueDepth-entry queue.
// Reset: synchronous active-low rst_n clears scan state and empties the queue.
module token_scanner #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tksc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tksc_pkg::out_item_t out_data
);

  // Bundle handoff between the scanner and the serializer.
  logic              bq_valid;
  logic              bq_full;
  tksc_pkg::bundle_t bq_data;

  // Classify each beat and compute all of its results combinationally.
  tksc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .bq_valid (bq_valid),
    .bq_full  (bq_full),
    .bq_data  (bq_data)
  );

  // Queue bundles and emit their results one beat at a time.
  tksc_back #(.Depth(QueueDepth)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .bq_valid  (bq_valid),
    .bq_full   (bq_full),
    .bq_data   (bq_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
